// ===== rtl/shift_insert_array_table_unit_defines.svh =====
// Assertion macros shared by the checker of the array table unit.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef SHIFT_INSERT_ARRAY_TABLE_UNIT_DEFINES_SVH
`define SHIFT_INSERT_ARRAY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define SIAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define SIAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/siat_pkg.sv =====
// Shared types for the array table unit: command and status codes.
// No dependencies; used by the top level, its checker, the scoreboard and the testbench.
package siat_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

endpackage

// ===== rtl/shift_insert_array_table_unit.sv =====
// Array table unit: a bounded table of signed 32-bit words held in one
// synchronous memory. Depends on siat_pkg.
//
// Usage: one command item enters on the input channel (in_valid_i/in_ready_o)
// with command_i, index_i and value_i. Exactly one result item leaves on the
// output channel (out_valid_o/out_ready_i) with read_value_o, length_o and
// status_o. Commands are processed one at a time; in_ready_o is high only
// while the unit waits for a new item.
// Writes inside the table, reads, refused or missing commands and removes of
// the last entry move no entries; other removes shift the entries above the
// index down, inserts inside the table shift the entries from the index up,
// and an extension zero-fills the gap past the end before placing the word.
// The memory's single write port means that shifted and zero-filled entries
// are written one at a time, with each read issued ahead of the write it
// feeds. The result register lets the next item be accepted while a result
// still waits; if the receiver stalls, a finished item holds in the unit
// until the register frees, and no new item is taken meanwhile.
// Reset empties the table (length 0); memory contents are never cleared,
// since an entry is always written before it becomes live.
module shift_insert_array_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [5:0]         index_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic [6:0]         length_o,
  output logic [1:0]         status_o
);
  import siat_pkg::*;

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW  = $clog2(CAPACITY + 1);
  localparam int CW  = (LW > 7) ? LW : 7;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW-1:0] OneC = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_READ,
    S_RESP
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        cnt_new_q;
  logic [CW-1:0]        ptr_q;
  logic [CW-1:0]        idx_q;
  logic signed [31:0]   val_q;
  logic signed [31:0]   res_rd_q;
  status_e              res_st_q;
  logic                 out_valid_q;
  logic signed [31:0]   out_rd_q;
  logic [6:0]           out_len_q;
  status_e              out_st_q;

  // Table storage: one write and one registered read per cycle.
  logic signed [31:0]   mem_q [CAPACITY];
  logic signed [31:0]   mem_rdata_q;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic signed [31:0]   mem_wdata;

  logic                 in_fire;
  logic [CW-1:0]        idx_ext;
  logic [CW-1:0]        idx_inc;
  logic [CW-1:0]        cnt_dec;
  logic [CW-1:0]        ptr_inc;
  logic [CW-1:0]        ptr_dec;
  logic                 hit;
  logic                 fits;
  logic                 not_full;
  logic                 rm_last;
  cmd_e                 cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(command_i);
  assign idx_ext    = CW'(index_i);
  assign idx_inc    = idx_ext + OneC;
  assign cnt_dec    = cnt_q - OneC;
  assign ptr_inc    = ptr_q + OneC;
  assign ptr_dec    = ptr_q - OneC;
  assign hit        = (idx_ext < cnt_q);
  assign fits       = (idx_ext < CapC);
  assign not_full   = (cnt_q < CapC);
  assign rm_last    = (idx_ext == cnt_dec);

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rd_q;
  assign length_o     = out_len_q;
  assign status_o     = out_st_q;

  // Memory port control: each read is issued in the cycle before the write it feeds.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr_q[AW-1:0];
    mem_raddr = idx_ext[AW-1:0];
    mem_wdata = mem_rdata_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && hit) begin
          case (cmd)
            CMD_READ: begin
              mem_re = 1'b1;
            end
            CMD_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = idx_ext[AW-1:0];
              mem_wdata = value_i;
            end
            CMD_INSERT: begin
              mem_re    = not_full;
              mem_raddr = cnt_dec[AW-1:0];
            end
            default: begin
              mem_re    = !rm_last;
              mem_raddr = idx_inc[AW-1:0];
            end
          endcase
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = (ptr_q == idx_q) ? val_q : '0;
      end
      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_re    = (ptr_dec != idx_q);
        mem_raddr = ptr_dec[AW-1:0] - AW'(1);
      end
      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_re    = (ptr_inc != cnt_dec);
        mem_raddr = ptr_inc[AW-1:0] + AW'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Synchronous memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // Command sequencer, live length and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cnt_new_q   <= '0;
      ptr_q       <= '0;
      idx_q       <= '0;
      val_q       <= '0;
      res_rd_q    <= '0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_rd_q    <= '0;
      out_len_q   <= '0;
      out_st_q    <= ST_OK;
    end else begin
      // A taken result item frees the register unless a new one loads now.
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            idx_q    <= idx_ext;
            val_q    <= value_i;
            res_rd_q <= '0;
            res_st_q <= ST_OK;
            state_q  <= S_RESP;
            unique case (cmd)
              CMD_INSERT, CMD_WRITE: begin
                if (!hit) begin
                  // Past the end: zero-fill the gap, then place the word.
                  if (fits) begin
                    ptr_q     <= cnt_q;
                    cnt_new_q <= idx_inc;
                    state_q   <= S_FILL;
                  end else begin
                    res_st_q <= ST_FULL;
                  end
                end else if (cmd == CMD_INSERT) begin
                  if (not_full) begin
                    ptr_q     <= cnt_q;
                    cnt_new_q <= cnt_q + OneC;
                    state_q   <= S_SHIFT_UP;
                  end else begin
                    res_st_q <= ST_FULL;
                  end
                end
              end
              CMD_READ: begin
                if (hit) begin
                  state_q <= S_READ;
                end else begin
                  res_st_q <= ST_MISSING;
                end
              end
              CMD_REMOVE: begin
                if (!hit) begin
                  res_st_q <= ST_MISSING;
                end else if (rm_last) begin
                  cnt_q <= cnt_dec;
                end else begin
                  ptr_q   <= idx_ext;
                  state_q <= S_SHIFT_DN;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          if (ptr_q == idx_q) begin
            cnt_q   <= cnt_new_q;
            state_q <= S_RESP;
          end else begin
            ptr_q <= ptr_inc;
          end
        end
        S_SHIFT_UP: begin
          // The entry below the pointer moved up; the word is then placed at the index.
          ptr_q <= ptr_dec;
          if (ptr_dec == idx_q) begin
            state_q <= S_FILL;
          end
        end
        S_SHIFT_DN: begin
          if (ptr_inc == cnt_dec) begin
            cnt_q   <= cnt_dec;
            state_q <= S_RESP;
          end else begin
            ptr_q <= ptr_inc;
          end
        end
        S_READ: begin
          res_rd_q <= mem_rdata_q;
          state_q  <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_rd_q    <= res_rd_q;
            out_len_q   <= cnt_q[6:0];
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/siat_checker.sv =====
// Port-level checker for the array table unit, bound to the top level.
// Depends on siat_pkg and shift_insert_array_table_unit_defines.svh.
`include "shift_insert_array_table_unit_defines.svh"

module siat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_value_o,
  input logic [6:0]  length_o,
  input logic [1:0]  status_o
);
  import siat_pkg::*;

  // A stalled result item keeps its valid and its payload.
  `SIAT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable({read_value_o, length_o, status_o}), "result item changed while stalled")

  // A result item with a failed status carries a zero word.
  `SIAT_ASSERT_NOW(a_err_zero, out_valid_o && (status_o != ST_OK), read_value_o == '0, "failed command returned a nonzero word")

  // One command at a time: the input closes right after an item is taken.
  `SIAT_ASSERT_NEXT(a_one_cmd, in_valid_i && in_ready_o, !in_ready_o, "second item accepted while a command was in progress")

  // No status code outside the defined set.
  `SIAT_ASSERT_NOW(a_status, out_valid_o, (status_o == ST_OK) || (status_o == ST_MISSING) || (status_o == ST_FULL), "undefined status code")

endmodule

bind shift_insert_array_table_unit siat_checker u_siat_checker (.*);

// ===== verif/siat_table_scoreboard_pkg.sv =====
// Scoreboard for the array table unit: keeps its own copy of the table,
// predicts one result per accepted command and checks results in order.
// Depends on siat_pkg for the command and status codes.
package siat_table_scoreboard_pkg;

  import siat_pkg::*;

  class siat_table_scoreboard;

    localparam int unsigned DEPTH = 64;

    typedef struct {
      logic signed [31:0] read_value;
      logic [6:0]         length;
      status_e            status;
    } table_result_t;

    // Predicted table contents and live length.
    logic signed [31:0] words [DEPTH];
    int unsigned        live_len;
    table_result_t      expected_q [$];
    int unsigned        mismatches;
    int unsigned        results_seen;

    function new();
      live_len     = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      $display("table mismatch at result %0d: %s", results_seen, what);
      mismatches++;
    endtask

    // Make pos the last live entry, zero-filling any gap. Refused past capacity.
    function bit extend_table(int unsigned pos, logic signed [31:0] word);
      int unsigned k;
      if (pos >= DEPTH) begin
        return 1'b0;
      end
      for (k = live_len; k < pos; k++) begin
        words[k] = '0;
      end
      words[pos] = word;
      live_len   = pos + 1;
      return 1'b1;
    endfunction

    // Apply one accepted command to the table copy and queue its result.
    function void note_command(cmd_e cmd, logic [5:0] idx, logic signed [31:0] word);
      table_result_t res;
      int unsigned   pos;
      int unsigned   k;
      pos            = idx;
      res.read_value = '0;
      res.status     = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (pos >= live_len) begin
            if (!extend_table(pos, word)) res.status = ST_FULL;
          end else if (live_len >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (k = live_len; k > pos; k--) begin
              words[k] = words[k - 1];
            end
            words[pos] = word;
            live_len++;
          end
        end
        CMD_WRITE: begin
          if (pos < live_len) begin
            words[pos] = word;
          end else if (!extend_table(pos, word)) begin
            res.status = ST_FULL;
          end
        end
        CMD_READ: begin
          if (pos < live_len) res.read_value = words[pos];
          else res.status = ST_MISSING;
        end
        default: begin
          if (pos < live_len) begin
            for (k = pos; k + 1 < live_len; k++) begin
              words[k] = words[k + 1];
            end
            live_len--;
          end else begin
            res.status = ST_MISSING;
          end
        end
      endcase
      res.length = live_len[6:0];
      expected_q.push_back(res);
    endfunction

    // Compare one result item against the oldest prediction.
    task check_result(logic signed [31:0] read_value, logic [6:0] length,
                      logic [1:0] status);
      table_result_t exp_res;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result arrived with no command pending");
        return;
      end
      exp_res = expected_q.pop_front();
      if (read_value !== exp_res.read_value) begin
        report_mismatch($sformatf("read_value got %0d expected %0d",
                                  read_value, exp_res.read_value));
      end
      if (length !== exp_res.length) begin
        report_mismatch($sformatf("length got %0d expected %0d", length, exp_res.length));
      end
      if (status !== exp_res.status) begin
        report_mismatch($sformatf("status got %0d expected %s", status,
                                  exp_res.status.name()));
      end
    endtask

  endclass

endpackage

// ===== verif/shift_insert_array_table_unit_test.sv =====
// Top-level testbench of the array table unit: directed and random command
// streams with random idling on both channels. Depends on siat_pkg,
// siat_table_scoreboard_pkg and the unit itself.
module shift_insert_array_table_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import siat_pkg::*;
  import siat_table_scoreboard_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1730;
  localparam int unsigned TAIL_CYCLES  = 100;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned TABLE_DEPTH  = 64;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         command_i;
  logic [5:0]         index_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] read_value_o;
  logic [6:0]         length_o;
  logic [1:0]         status_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;
  bit          shrinking;

  siat_table_scoreboard table_sb;

  shift_insert_array_table_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .length_o     (length_o),
    .status_o     (status_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver side: ready drops at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every result item goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      table_sb.check_result(read_value_o, length_o, status_o);
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("shift_insert_array_table_unit regression: fail");
    $finish;
  end

  // Present one command item, idling first at random, and hold it until taken.
  task automatic send_table_command(input cmd_e cmd, input logic [5:0] idx,
                                    input logic signed [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    index_i    <= idx;
    value_i    <= word;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    table_sb.note_command(cmd, idx, word);
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic wait_for_table_drain();
    in_valid_i <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Index biased toward the live part and the positions just past its end.
  function automatic logic [5:0] pick_table_index(int unsigned len);
    int unsigned roll;
    int unsigned pos;
    roll = $urandom_range(99);
    if (len > 0 && roll < 55) begin
      pos = $urandom_range(len - 1, 0);
    end else if (roll < 80) begin
      pos = len + $urandom_range(2);
      if (pos > TABLE_DEPTH - 1) pos = TABLE_DEPTH - 1;
    end else begin
      pos = $urandom_range(TABLE_DEPTH - 1);
    end
    return pos[5:0];
  endfunction

  function automatic logic signed [31:0] pick_table_word();
    case ($urandom_range(39))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Commands lean toward growth or shrinkage so the length sweeps its range.
  function automatic cmd_e pick_table_command(bit shrink);
    int unsigned roll;
    roll = $urandom_range(99);
    if (!shrink) begin
      if (roll < 35) return CMD_INSERT;
      if (roll < 60) return CMD_WRITE;
      if (roll < 80) return CMD_READ;
      return CMD_REMOVE;
    end
    if (roll < 15) return CMD_INSERT;
    if (roll < 25) return CMD_WRITE;
    if (roll < 50) return CMD_READ;
    return CMD_REMOVE;
  endfunction

  // Directed items: empty table, gaps, shifts, a full table and extreme words.
  task automatic run_directed_commands();
    send_table_command(CMD_READ,   6'd0,  32'sd0);
    send_table_command(CMD_REMOVE, 6'd5,  32'sd0);
    send_table_command(CMD_INSERT, 6'd0,  32'sh7fffffff);
    send_table_command(CMD_INSERT, 6'd5,  32'sh80000000);
    send_table_command(CMD_READ,   6'd3,  32'sd0);
    send_table_command(CMD_INSERT, 6'd2,  -32'sd1);
    send_table_command(CMD_WRITE,  6'd0,  32'sd0);
    send_table_command(CMD_WRITE,  6'd9,  32'sh12345678);
    send_table_command(CMD_READ,   6'd6,  32'sd0);
    send_table_command(CMD_REMOVE, 6'd0,  32'sd0);
    send_table_command(CMD_REMOVE, 6'd8,  32'sd0);
    send_table_command(CMD_READ,   6'd8,  32'sd0);
    send_table_command(CMD_WRITE,  6'd63, 32'sh55555555);
    send_table_command(CMD_INSERT, 6'd10, 32'sd1);
    send_table_command(CMD_INSERT, 6'd63, 32'sd2);
    send_table_command(CMD_WRITE,  6'd63, 32'shaaaaaaaa);
    send_table_command(CMD_READ,   6'd63, 32'sd0);
    send_table_command(CMD_REMOVE, 6'd63, 32'sd0);
    send_table_command(CMD_INSERT, 6'd63, -32'sd2);
    send_table_command(CMD_REMOVE, 6'd0,  32'sd0);
    send_table_command(CMD_READ,   6'd62, 32'sd0);
    send_table_command(CMD_INSERT, 6'd0,  32'sh7fffffff);
    send_table_command(CMD_READ,   6'd0,  32'sd0);
  endtask

  // Main sequence: reset, directed part, three idling phases of random items.
  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_READ;
    index_i       = '0;
    value_i       = '0;
    send_idle_pct = 34;
    recv_idle_pct = 45;
    shrinking     = 1'b0;
    table_sb      = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed_commands();
    wait_for_table_drain();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 34;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n % 400 == 200) wait_for_table_drain();
      send_table_command(pick_table_command(shrinking),
                         pick_table_index(table_sb.live_len), pick_table_word());
      if (table_sb.live_len >= TABLE_DEPTH) shrinking = 1'b1;
      else if (table_sb.live_len == 0) shrinking = 1'b0;
      else if ($urandom_range(149) == 0) shrinking = !shrinking;
    end

    wait_for_table_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (table_sb.mismatches == 0) begin
      $display("shift_insert_array_table_unit regression: pass");
    end else begin
      $display("shift_insert_array_table_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== shift_insert_array_table_unit.f =====
+incdir+rtl
rtl/siat_pkg.sv
rtl/shift_insert_array_table_unit.sv
rtl/siat_checker.sv
verif/siat_table_scoreboard_pkg.sv
verif/shift_insert_array_table_unit_test.sv
